// ===== rtl/rbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared widths, codes and the request type passed from front to back.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // canvas geometry
  localparam int MAX_SIDE    = 256;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PIX_W       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  // fixed point
  localparam int FRAC_W    = 16;
  localparam int ONE_Q16   = 1 << FRAC_W;
  localparam int RAD_W     = FRAC_W + SIDE_W;
  localparam int RAD_MAX   = MAX_SIDE * ONE_Q16;
  localparam int RAD2_W    = 2 * RAD_W;
  localparam int CRD_W     = $clog2(2 * MAX_SIDE + 2) + 1;
  localparam int ABS_W     = CRD_W + FRAC_W;
  localparam int DIST2_W   = 2 * ABS_W + 1;
  localparam int AMT_W     = 24;
  localparam int FALL_W    = FRAC_W + 1;
  localparam int QUO_STEPS = FRAC_W + 1;
  localparam int STEP_W    = $clog2(RAD_W + 1);
  localparam int TOT_W     = 42;

  // request queue
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH   = 3'd0,
    REG_CANVAS_HEIGHT  = 3'd1,
    REG_CHANNEL_SELECT = 3'd2,
    REG_UV_SCALE       = 3'd3,
    REG_UV_OFFSET_U    = 3'd4,
    REG_UV_OFFSET_V    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_DAB   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_DAB   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [ADDR_W-1:0]        index;
    logic [31:0]              value;
    logic [1:0]               lane;
    logic [SIDE_W-1:0]        w;
    logic [SIDE_W-1:0]        h;
    logic [RAD_W-1:0]         cx;
    logic [RAD_W-1:0]         cy;
    logic [RAD_W-1:0]         r;
    logic [RAD2_W-1:0]        r2;
    logic signed [CRD_W-1:0]  x0;
    logic signed [CRD_W-1:0]  x1;
    logic signed [CRD_W-1:0]  y0;
    logic signed [CRD_W-1:0]  y1;
    logic [PIX_W-1:0]         px0;
    logic [PIX_W-1:0]         py0;
    logic signed [AMT_W-1:0]  amount;
  } queue_entry_t;

endpackage

// ===== rtl/radial_brush_dab_canvas_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_brush_dab_canvas_core
// RGBA8 canvas with texel load/readback and linear-falloff radial dab painting.
// ----------------------------------------------------------------------------
//  port group  | handshake          | carries
//  ------------+--------------------+-----------------------------------------
//  cfg_        | cfg_we             | register index, 24-bit write data
//  in_         | in_valid/in_ready  | func, texel index/value, dab u/v/r/str
//  out_        | out_valid/out_ready| read_value, canvas_dirty
//
//  A texel write passes the front's push state, the queue and the back's
//  start and done states; a read adds a read-data state. A dab runs the
//  front's setup states up to the push, then per footprint position over
//  (x1-x0+1)*(y1-y0+1) squares and sums the distance, and inside the radius
//  adds a 25-step square root and 17-step falloff divide (one digit per cycle).
//  Reset restores configuration defaults and clears the dirty flag; the
//  canvas memory is not cleared and reads back undefined until written.
//  The request queue lets the front accept and set up the next request while
//  the back is busy or a result waits for out_ready.
// ----------------------------------------------------------------------------
module radial_brush_dab_canvas_core
  import rbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [15:0]           in_texel_index,
  input  logic [31:0]           in_texel_value,
  input  logic signed [23:0]    in_dab_u,
  input  logic signed [23:0]    in_dab_v,
  input  logic [19:0]           in_dab_radius,
  input  logic signed [15:0]    in_dab_strength,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_read_value,
  output logic                  out_canvas_dirty
);

  logic         push_valid, push_ready;
  queue_entry_t push_entry;
  logic         pop_valid, pop_ready;
  queue_entry_t pop_entry;

  rbd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_texel_index  (in_texel_index),
    .in_texel_value  (in_texel_value),
    .in_dab_u        (in_dab_u),
    .in_dab_v        (in_dab_v),
    .in_dab_radius   (in_dab_radius),
    .in_dab_strength (in_dab_strength),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_entry      (push_entry)
  );

  rbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  rbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_entry        (pop_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .out_canvas_dirty (out_canvas_dirty)
  );

endmodule

// ===== rtl/rbd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_queue
// Short request queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module rbd_queue
  import rbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  queue_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop_ready,
  output queue_entry_t pop_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // hold request payloads
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");

endmodule

// ===== rtl/rbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_front
// Holds configuration, accepts requests and classifies them; for a dab it
// computes centre, radius, bounding box and wrapped start pixel.
// ----------------------------------------------------------------------------
module rbd_front
  import rbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [15:0]            in_texel_index,
  input  logic [31:0]            in_texel_value,
  input  logic signed [23:0]     in_dab_u,
  input  logic signed [23:0]     in_dab_v,
  input  logic [19:0]            in_dab_radius,
  input  logic signed [15:0]     in_dab_strength,
  output logic                   push_valid,
  input  logic                   push_ready,
  output queue_entry_t           push_entry
);

  localparam int RAD1_W  = 28;
  localparam int RAD2P_W = RAD1_W + SIDE_W;
  localparam int MCNT_W  = $clog2(SIDE_W + 1);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_MUL  = 8'b0000_0010,
    F_CTR  = 8'b0000_0100,
    F_RAD  = 8'b0000_1000,
    F_BOX  = 8'b0001_0000,
    F_MOD  = 8'b0010_0000,
    F_FIX  = 8'b0100_0000,
    F_PUSH = 8'b1000_0000
  } fstate_t;

  fstate_t state_r, state_nxt;

  // configuration
  logic [8:0]         width_r, height_r;
  logic [1:0]         lane_r;
  logic signed [23:0] scale_r, offu_r, offv_r;

  // latched request
  logic signed [23:0] u_r, v_r;
  logic [19:0]        radius_r;
  logic signed [15:0] strength_r;

  // dab setup datapath
  logic [31:0]         prod_u_r, prod_v_r;
  logic [RAD1_W-1:0]   rad1_r;
  logic [RAD2P_W-1:0]  rad2_r;
  logic [SIDE_W-1:0]   mx_a_r, my_a_r, mx_rem_r, my_rem_r;
  logic [MCNT_W-1:0]   mcnt_r;
  queue_entry_t        entry_r;

  logic [SIDE_W-1:0]   w_eff, h_eff, min_wh;
  logic signed [47:0]  mul_u, mul_v;
  logic [23:0]         abs_scale;
  logic [43:0]         rad1_full;
  logic [15:0]         fu, fv;
  logic [RAD2P_W-1:0]  rad2_full;
  logic [RAD_W+1:0]    x_lo, y_lo, x_hi, y_hi;
  logic signed [CRD_W-1:0] x0_w, y0_w;
  logic [SIDE_W:0]     mx_try, my_try;
  logic signed [AMT_W-1:0] str_ext;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'(MAX_SIDE);
      height_r <= 9'(MAX_SIDE);
      lane_r   <= '0;
      scale_r  <= 24'(ONE_Q16);
      offu_r   <= '0;
      offv_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CANVAS_WIDTH:   width_r  <= cfg_wdata[8:0];
        REG_CANVAS_HEIGHT:  height_r <= cfg_wdata[8:0];
        REG_CHANNEL_SELECT: lane_r   <= cfg_wdata[1:0];
        REG_UV_SCALE:       scale_r  <= cfg_wdata;
        REG_UV_OFFSET_U:    offu_r   <= cfg_wdata;
        REG_UV_OFFSET_V:    offv_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturate sides to the store size
  assign w_eff  = (width_r > 9'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(width_r);
  assign h_eff  = (height_r > 9'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(height_r);
  assign min_wh = (w_eff < h_eff) ? w_eff : h_eff;

  // mapping products
  assign mul_u     = u_r * scale_r;
  assign mul_v     = v_r * scale_r;
  assign abs_scale = scale_r[23] ? 24'(-scale_r) : 24'(scale_r);
  assign rad1_full = radius_r * abs_scale;

  // wrapped fraction and scaled radius
  assign fu        = prod_u_r[31:16] + offu_r[15:0];
  assign fv        = prod_v_r[31:16] + offv_r[15:0];
  assign rad2_full = RAD2P_W'(rad1_r) * RAD2P_W'(min_wh);

  // bounding box
  assign x_lo = {2'b00, entry_r.cx} - {2'b00, entry_r.r};
  assign y_lo = {2'b00, entry_r.cy} - {2'b00, entry_r.r};
  assign x_hi = {2'b00, entry_r.cx} + {2'b00, entry_r.r} + (RAD_W+2)'(ONE_Q16 - 1);
  assign y_hi = {2'b00, entry_r.cy} + {2'b00, entry_r.r} + (RAD_W+2)'(ONE_Q16 - 1);
  assign x0_w = CRD_W'($signed(x_lo) >>> FRAC_W);
  assign y0_w = CRD_W'($signed(y_lo) >>> FRAC_W);

  // one restoring remainder step per cycle
  assign mx_try = {mx_rem_r, mx_a_r[SIDE_W-1]};
  assign my_try = {my_rem_r, my_a_r[SIDE_W-1]};

  assign str_ext = AMT_W'(strength_r);

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_entry = entry_r;

  // sequence the setup
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          if (func_t'(in_func) == FUNC_DAB && w_eff != '0 && h_eff != '0) begin
            state_nxt = F_MUL;
          end else begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_MUL:  state_nxt = F_CTR;
      F_CTR:  state_nxt = F_RAD;
      F_RAD:  state_nxt = F_BOX;
      F_BOX:  state_nxt = F_MOD;
      F_MOD:  if (mcnt_r == MCNT_W'(1)) state_nxt = F_FIX;
      F_FIX:  state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        u_r        <= in_dab_u;
        v_r        <= in_dab_v;
        radius_r   <= in_dab_radius;
        strength_r <= in_dab_strength;
        entry_r.index <= ADDR_W'(in_texel_index);
        entry_r.value <= in_texel_value;
        entry_r.lane  <= lane_r;
        entry_r.w     <= w_eff;
        entry_r.h     <= h_eff;
        case (func_t'(in_func))
          FUNC_WRITE: entry_r.op <= (32'(in_texel_index) < STORE_DEPTH) ? OP_WRITE : OP_NOP;
          FUNC_READ:  entry_r.op <= (32'(in_texel_index) < STORE_DEPTH) ? OP_READ : OP_NOP;
          FUNC_DAB:   entry_r.op <= (w_eff != '0 && h_eff != '0) ? OP_DAB : OP_NOP;
          default:    entry_r.op <= OP_NOP;
        endcase
      end
      F_MUL: begin
        prod_u_r <= mul_u[31:0];
        prod_v_r <= mul_v[31:0];
        rad1_r   <= rad1_full[43:16];
        entry_r.amount <= (str_ext <<< 8) - str_ext;
      end
      F_CTR: begin
        entry_r.cx <= RAD_W'(fu) * RAD_W'(entry_r.w);
        entry_r.cy <= RAD_W'(fv) * RAD_W'(entry_r.h);
        rad2_r     <= rad2_full;
      end
      F_RAD: begin
        if (rad2_r < RAD2P_W'(ONE_Q16)) begin
          entry_r.r <= RAD_W'(ONE_Q16);
        end else if (rad2_r > RAD2P_W'(RAD_MAX)) begin
          entry_r.r <= RAD_W'(RAD_MAX);
        end else begin
          entry_r.r <= RAD_W'(rad2_r);
        end
      end
      F_BOX: begin
        entry_r.r2 <= RAD2_W'(entry_r.r) * RAD2_W'(entry_r.r);
        entry_r.x0 <= x0_w;
        entry_r.y0 <= y0_w;
        entry_r.x1 <= CRD_W'(x_hi >> FRAC_W);
        entry_r.y1 <= CRD_W'(y_hi >> FRAC_W);
        mx_a_r   <= x0_w[CRD_W-1] ? SIDE_W'(-x0_w) : SIDE_W'(x0_w);
        my_a_r   <= y0_w[CRD_W-1] ? SIDE_W'(-y0_w) : SIDE_W'(y0_w);
        mx_rem_r <= '0;
        my_rem_r <= '0;
        mcnt_r   <= MCNT_W'(SIDE_W);
      end
      F_MOD: begin
        mx_rem_r <= (mx_try >= {1'b0, entry_r.w}) ? SIDE_W'(mx_try - {1'b0, entry_r.w})
                                                  : SIDE_W'(mx_try);
        my_rem_r <= (my_try >= {1'b0, entry_r.h}) ? SIDE_W'(my_try - {1'b0, entry_r.h})
                                                  : SIDE_W'(my_try);
        mx_a_r   <= mx_a_r << 1;
        my_a_r   <= my_a_r << 1;
        mcnt_r   <= mcnt_r - 1'b1;
      end
      F_FIX: begin
        entry_r.px0 <= (entry_r.x0[CRD_W-1] && mx_rem_r != '0)
                       ? PIX_W'(entry_r.w - mx_rem_r) : PIX_W'(mx_rem_r);
        entry_r.py0 <= (entry_r.y0[CRD_W-1] && my_rem_r != '0)
                       ? PIX_W'(entry_r.h - my_rem_r) : PIX_W'(my_rem_r);
      end
      default: ;
    endcase
  end

  a_dab_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_entry.op == OP_DAB) |->
      (push_entry.r >= RAD_W'(ONE_Q16) && push_entry.r <= RAD_W'(RAD_MAX)))
    else $error("dab radius outside clamp range");

  a_dab_start: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_entry.op == OP_DAB) |->
      (SIDE_W'(push_entry.px0) < push_entry.w && SIDE_W'(push_entry.py0) < push_entry.h &&
       push_entry.x0 <= push_entry.x1 && push_entry.y0 <= push_entry.y1))
    else $error("dab start pixel or box inconsistent");

  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_entry)))
    else $error("stalled request changed");

endmodule

// ===== rtl/rbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_back
// Executes queued requests on the canvas memory: texel write and read, and
// the dab walk with square root, falloff divide and saturating lane update.
// ----------------------------------------------------------------------------
module rbd_back
  import rbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  queue_entry_t pop_entry,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_read_value,
  output logic         out_canvas_dirty
);

  localparam int DX_W = CRD_W + FRAC_W + 1;

  typedef enum logic [10:0] {
    B_IDLE  = 11'b000_0000_0001,
    B_START = 11'b000_0000_0010,
    B_RD    = 11'b000_0000_0100,
    B_SQ    = 11'b000_0000_1000,
    B_SUM   = 11'b000_0001_0000,
    B_SQRT  = 11'b000_0010_0000,
    B_DIV   = 11'b000_0100_0000,
    B_MUL   = 11'b000_1000_0000,
    B_UPD   = 11'b001_0000_0000,
    B_NEXT  = 11'b010_0000_0000,
    B_DONE  = 11'b100_0000_0000
  } bstate_t;

  bstate_t state_r, state_nxt;

  queue_entry_t            item_r;
  logic signed [CRD_W-1:0] x_r, y_r;
  logic [PIX_W-1:0]        px_r, py_r;
  logic [2*ABS_W-1:0]      asq_r, bsq_r;
  logic [ADDR_W-1:0]       idx_r;
  logic [RAD2_W-1:0]       sq_n_r;
  logic [RAD_W+1:0]        sq_rem_r;
  logic [RAD_W-1:0]        sq_root_r;
  logic [RAD_W:0]          dv_rem_r;
  logic [FALL_W-1:0]       dv_q_r;
  logic [FALL_W-1:0]       fall_r;
  logic [STEP_W-1:0]       cnt_r;
  logic signed [TOT_W-1:0] prod_r;
  logic [31:0]             rd_val_r;
  logic                    dirty_r;
  logic                    out_valid_r;
  logic [31:0]             out_value_r;
  logic                    out_dirty_r;

  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [31:0]             ram_wdata, ram_rdata;

  logic signed [DX_W-1:0]  dx, dy;
  logic [ABS_W-1:0]        adx, ady;
  logic [DIST2_W-1:0]      d2;
  logic [RAD_W+3:0]        sq_cur, sq_trial;
  logic [RAD_W+1:0]        sq_rem_nxt;
  logic [RAD_W-1:0]        sq_root_nxt;
  logic                    dv_ge;
  logic [RAD_W-1:0]        dv_diff;
  logic [FALL_W-1:0]       dv_q_nxt;
  logic [4:0]              lane_base;
  logic [7:0]              lane_val, lane_new;
  logic signed [TOT_W-1:0] total;
  logic [31:0]             texel_new;
  logic                    x_last, y_last;
  logic [PIX_W-1:0]        px_inc, py_inc;

  rbd_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // take a request only when the result slot is free
  assign pop_ready        = (state_r == B_IDLE) && !out_valid_r;
  assign out_valid        = out_valid_r;
  assign out_read_value   = out_value_r;
  assign out_canvas_dirty = out_dirty_r;

  // distance from pixel centre to dab centre
  assign dx  = $signed({x_r[CRD_W-1], x_r, 1'b1, 15'b0})
             - $signed({{(DX_W-RAD_W){1'b0}}, item_r.cx});
  assign dy  = $signed({y_r[CRD_W-1], y_r, 1'b1, 15'b0})
             - $signed({{(DX_W-RAD_W){1'b0}}, item_r.cy});
  assign adx = dx[DX_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
  assign ady = dy[DX_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
  assign d2  = DIST2_W'(asq_r) + DIST2_W'(bsq_r);

  // one square root digit per cycle
  assign sq_cur   = {sq_rem_r, sq_n_r[RAD2_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  always_comb begin
    if (sq_cur >= sq_trial) begin
      sq_rem_nxt  = (RAD_W+2)'(sq_cur - sq_trial);
      sq_root_nxt = {sq_root_r[RAD_W-2:0], 1'b1};
    end else begin
      sq_rem_nxt  = sq_cur[RAD_W+1:0];
      sq_root_nxt = {sq_root_r[RAD_W-2:0], 1'b0};
    end
  end

  // one quotient bit per cycle
  assign dv_ge    = (dv_rem_r >= {1'b0, item_r.r});
  assign dv_diff  = dv_ge ? RAD_W'(dv_rem_r - {1'b0, item_r.r}) : RAD_W'(dv_rem_r);
  assign dv_q_nxt = {dv_q_r[FALL_W-2:0], dv_ge};

  // lane update with saturation
  assign lane_base = {item_r.lane, 3'b000};
  assign lane_val  = ram_rdata[lane_base +: 8];
  assign total     = $signed({3'b000, lane_val, 31'b0}) + prod_r;
  always_comb begin
    if (total[TOT_W-1] || total == '0) begin
      lane_new = 8'd0;
    end else if (total[TOT_W-1:31] > 11'd255) begin
      lane_new = 8'd255;
    end else begin
      lane_new = total[38:31];
    end
    texel_new = ram_rdata;
    texel_new[lane_base +: 8] = lane_new;
  end

  // footprint walk with toroidal wrap
  assign x_last = (x_r == item_r.x1);
  assign y_last = (y_r == item_r.y1);
  assign px_inc = ((SIDE_W'(px_r) + 1'b1) == item_r.w) ? '0 : px_r + 1'b1;
  assign py_inc = ((SIDE_W'(py_r) + 1'b1) == item_r.h) ? '0 : py_r + 1'b1;

  // memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_r.index;
    ram_wdata = item_r.value;
    ram_re    = 1'b0;
    ram_raddr = item_r.index;
    case (state_r)
      B_START: begin
        ram_we = (item_r.op == OP_WRITE);
        ram_re = (item_r.op == OP_READ);
      end
      B_MUL: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
      end
      B_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = texel_new;
      end
      default: ;
    endcase
  end

  // sequence execution
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (pop_valid && pop_ready) state_nxt = B_START;
      B_START: begin
        case (item_r.op)
          OP_READ: state_nxt = B_RD;
          OP_DAB:  state_nxt = B_SQ;
          default: state_nxt = B_DONE;
        endcase
      end
      B_RD:    state_nxt = B_DONE;
      B_SQ:    state_nxt = B_SUM;
      B_SUM:   state_nxt = (d2 > DIST2_W'(item_r.r2)) ? B_NEXT : B_SQRT;
      B_SQRT:  if (cnt_r == STEP_W'(1)) state_nxt = B_DIV;
      B_DIV:   if (cnt_r == STEP_W'(1)) state_nxt = B_MUL;
      B_MUL:   state_nxt = B_UPD;
      B_UPD:   state_nxt = B_NEXT;
      B_NEXT:  state_nxt = (x_last && y_last) ? B_DONE : B_SQ;
      B_DONE:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_START && item_r.op == OP_DAB) begin
        dirty_r <= 1'b1;
      end
      if (state_r == B_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        item_r <= pop_entry;
      end
      B_START: begin
        rd_val_r <= '0;
        x_r      <= item_r.x0;
        y_r      <= item_r.y0;
        px_r     <= item_r.px0;
        py_r     <= item_r.py0;
      end
      B_RD: begin
        rd_val_r <= ram_rdata;
      end
      B_SQ: begin
        asq_r <= (2*ABS_W)'(adx) * (2*ABS_W)'(adx);
        bsq_r <= (2*ABS_W)'(ady) * (2*ABS_W)'(ady);
        idx_r <= ADDR_W'(py_r * item_r.w) + ADDR_W'(px_r);
      end
      B_SUM: begin
        sq_n_r    <= RAD2_W'(d2);
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        cnt_r     <= STEP_W'(RAD_W);
      end
      B_SQRT: begin
        sq_n_r    <= sq_n_r << 2;
        sq_rem_r  <= sq_rem_nxt;
        sq_root_r <= sq_root_nxt;
        if (cnt_r == STEP_W'(1)) begin
          dv_rem_r <= {1'b0, sq_root_nxt};
          dv_q_r   <= '0;
          cnt_r    <= STEP_W'(QUO_STEPS);
        end else begin
          cnt_r    <= cnt_r - 1'b1;
        end
      end
      B_DIV: begin
        dv_rem_r <= {dv_diff, 1'b0};
        dv_q_r   <= dv_q_nxt;
        cnt_r    <= cnt_r - 1'b1;
        fall_r   <= FALL_W'(ONE_Q16) - dv_q_nxt;
      end
      B_MUL: begin
        prod_r <= item_r.amount * $signed({1'b0, fall_r});
      end
      B_NEXT: begin
        if (x_last) begin
          x_r  <= item_r.x0;
          px_r <= item_r.px0;
          y_r  <= y_r + 1'b1;
          py_r <= py_inc;
        end else begin
          x_r  <= x_r + 1'b1;
          px_r <= px_inc;
        end
      end
      default: ;
    endcase
  end

  // load the result slot
  always_ff @(posedge clk) begin
    if (state_r == B_DONE) begin
      out_value_r <= rd_val_r;
      out_dirty_r <= dirty_r;
    end
  end

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE) |-> !out_valid_r)
    else $error("result slot overwritten");

  a_fall_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MUL) |-> (fall_r <= FALL_W'(ONE_Q16)))
    else $error("falloff above one");

  a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQ) |-> (SIDE_W'(px_r) < item_r.w && SIDE_W'(py_r) < item_r.h))
    else $error("wrapped pixel outside canvas");

  a_dirty_after_dab: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_START && item_r.op == OP_DAB) |=> dirty_r)
    else $error("dirty flag not set by dab");

endmodule

// ===== test/tb_radial_brush_dab_canvas_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_brush_dab_canvas_core
// Loads canvases texel by texel, paints dabs under a range of canvas sizes,
// lanes, UV scales and offsets, and reads texels back. A cycle-free canvas
// model predicts every result, which is compared in order as it is returned.
// Both handshake sides pause at random, and once the result side holds off
// long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_radial_brush_dab_canvas_core
  import rbd_pkg::*;
();

  localparam int IDLE_LIMIT = 200000;

  // --------------------------------------------------------------------------
  // canvas model and result store
  // --------------------------------------------------------------------------
  class canvas_scoreboard;
    typedef struct {
      logic [31:0] rd;
      logic        dirty;
    } canvas_result_t;

    logic [31:0]        texels [0:65535];
    bit                 written [0:65535];
    bit                 painted;
    logic [8:0]         width_q;
    logic [8:0]         height_q;
    logic [1:0]         lane_q;
    logic signed [23:0] scale_q;
    logic signed [23:0] off_u_q;
    logic signed [23:0] off_v_q;
    canvas_result_t     pending [$];
    int                 errors;
    int                 results;

    function new();
      painted  = 0;
      width_q  = 9'd256;
      height_q = 9'd256;
      lane_q   = 2'd0;
      scale_q  = 24'sd65536;
      off_u_q  = 0;
      off_v_q  = 0;
      errors   = 0;
      results  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] d);
      case (idx)
        REG_CANVAS_WIDTH:   width_q  = d[8:0];
        REG_CANVAS_HEIGHT:  height_q = d[8:0];
        REG_CHANNEL_SELECT: lane_q   = d[1:0];
        REG_UV_SCALE:       scale_q  = d;
        REG_UV_OFFSET_U:    off_u_q  = d;
        REG_UV_OFFSET_V:    off_v_q  = d;
        default: ;
      endcase
    endfunction

    // floor of a Q.16 value, in whole units
    function automatic longint q16_floor(longint v);
      return v >>> 16;
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function automatic longint wrapped_centre(logic signed [23:0] crd,
                                              logic signed [23:0] off);
      longint p;
      p = q16_floor(longint'(crd) * longint'(scale_q)) + longint'(off);
      return p & 64'hFFFF;
    endfunction

    function void paint(logic signed [23:0] u, logic signed [23:0] v,
                        logic [19:0] radius, logic signed [15:0] strength);
      longint w, h, sc, cx, cy, r, r2, amount, x0, x1, y0, y1;
      longint dx, dy, d2, root_d, fall, px, py, val, total, nv;
      int     idx;
      w = width_q;
      h = height_q;
      if (w == 0 || h == 0) return;
      if (w > MAX_SIDE) w = MAX_SIDE;
      if (h > MAX_SIDE) h = MAX_SIDE;
      sc = scale_q;
      if (sc < 0) sc = -sc;
      cx = wrapped_centre(u, off_u_q) * w;
      cy = wrapped_centre(v, off_v_q) * h;
      r = (longint'(radius) * sc) >> 16;
      r = r * ((w < h) ? w : h);
      if (r < ONE_Q16) r = ONE_Q16;
      if (r > longint'(MAX_SIDE) * ONE_Q16) r = longint'(MAX_SIDE) * ONE_Q16;
      r2 = r * r;
      amount = longint'(strength) * 255;
      x0 = q16_floor(cx - r);
      x1 = -q16_floor(-(cx + r));
      y0 = q16_floor(cy - r);
      y1 = -q16_floor(-(cy + r));
      for (longint y = y0; y <= y1; y++) begin
        dy = y * ONE_Q16 + 32768 - cy;
        if (dy < 0) dy = -dy;
        for (longint x = x0; x <= x1; x++) begin
          dx = x * ONE_Q16 + 32768 - cx;
          if (dx < 0) dx = -dx;
          d2 = dx * dx + dy * dy;
          if (d2 > r2) continue;
          root_d = int_root(d2);
          fall = ONE_Q16 - ((root_d << 16) / r);
          px = ((x % w) + w) % w;
          py = ((y % h) + h) % h;
          idx = int'(py * w + px);
          val = texels[idx][lane_q*8 +: 8];
          total = (val <<< 31) + amount * fall;
          if (total <= 0) nv = 0;
          else begin
            nv = total >>> 31;
            if (nv > 255) nv = 255;
          end
          texels[idx][lane_q*8 +: 8] = nv[7:0];
        end
      end
      painted = 1;
    endfunction

    // note one accepted request and queue what it must return
    function void note(func_t f, logic [15:0] idx, logic [31:0] val,
                       logic signed [23:0] u, logic signed [23:0] v,
                       logic [19:0] radius, logic signed [15:0] strength);
      canvas_result_t res;
      res.rd = 32'd0;
      case (f)
        FUNC_WRITE: begin
          texels[idx]  = val;
          written[idx] = 1;
        end
        FUNC_READ: res.rd = texels[idx];
        FUNC_DAB:  paint(u, v, radius, strength);
        default: ;
      endcase
      res.dirty = painted;
      pending.push_back(res);
    endfunction

    function void check(logic [31:0] rd, logic dirty);
      canvas_result_t exp_res;
      results++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: read_value %h", rd);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (rd !== exp_res.rd) begin
        $error("read_value: expected %h, got %h", exp_res.rd, rd);
        errors++;
      end
      if (dirty !== exp_res.dirty) begin
        $error("canvas_dirty: expected %0b, got %0b", exp_res.dirty, dirty);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_func;
  logic [15:0]           in_texel_index;
  logic [31:0]           in_texel_value;
  logic signed [23:0]    in_dab_u;
  logic signed [23:0]    in_dab_v;
  logic [19:0]           in_dab_radius;
  logic signed [15:0]    in_dab_strength;
  logic                  out_valid;
  logic                  out_ready;
  logic [31:0]           out_read_value;
  logic                  out_canvas_dirty;

  canvas_scoreboard sb = new();
  bit               calm;
  bit               held;
  int               idle_cycles;
  logic [15:0]      extra_written [$];

  radial_brush_dab_canvas_core dut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_request(func_t f, logic [15:0] idx, logic [31:0] val,
                              logic signed [23:0] u, logic signed [23:0] v,
                              logic [19:0] radius, logic signed [15:0] strength);
    int g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_texel_index  <= idx;
    in_texel_value  <= val;
    in_dab_u        <= u;
    in_dab_v        <= v;
    in_dab_radius   <= radius;
    in_dab_strength <= strength;
    do @(posedge clk); while (!in_ready);
    sb.note(f, idx, val, u, v, radius, strength);
  endtask

  task automatic write_texel(logic [15:0] idx, logic [31:0] val);
    send_request(FUNC_WRITE, idx, val, $urandom, $urandom, $urandom, $urandom);
  endtask

  // drop the request, drain, then write every register
  task automatic configure(int w, int h, int lane, int sc, int ou, int ov);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_reg_t r;
      logic [23:0] d;
      r = cfg_reg_t'(i);
      case (r)
        REG_CANVAS_WIDTH:   d = 24'(w);
        REG_CANVAS_HEIGHT:  d = 24'(h);
        REG_CHANNEL_SELECT: d = 24'(lane);
        REG_UV_SCALE:       d = 24'(sc);
        REG_UV_OFFSET_U:    d = 24'(ou);
        default:            d = 24'(ov);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= d;
      @(posedge clk);
      sb.set_reg(r, d);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int canvas_area();
    int w, h;
    w = (sb.width_q > MAX_SIDE) ? MAX_SIDE : sb.width_q;
    h = (sb.height_q > MAX_SIDE) ? MAX_SIDE : sb.height_q;
    return w * h;
  endfunction

  // random dab radius kept to a few pixels so the footprint stays small
  function automatic logic [19:0] pick_radius();
    longint a, m, lim;
    a = sb.scale_q;
    if (a < 0) a = -a;
    m = (sb.width_q < sb.height_q) ? sb.width_q : sb.height_q;
    if (m > MAX_SIDE) m = MAX_SIDE;
    if (m == 0) m = 1;
    lim = (a == 0) ? 64'hFFFFF : (64'd3 << 32) / (a * m);
    if (lim > 64'hFFFFF) lim = 64'hFFFFF;
    return $urandom_range(0, int'(lim));
  endfunction

  task automatic run_phase(int w, int h, int lane, int sc, int ou, int ov,
                           int n, bit quiet);
    int area;
    int p;
    logic [15:0] idx;
    configure(w, h, lane, sc, ou, ov);
    calm = quiet;
    area = canvas_area();
    // fill every texel a dab can reach
    for (int i = 0; i < area; i++)
      if (!sb.written[i]) write_texel(i, $urandom);
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        send_request(FUNC_DAB, $urandom, $urandom, $urandom, $urandom,
                     pick_radius(), $urandom);
      end else if (p < 75) begin
        if (area > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, area - 1);
        end else begin
          idx = $urandom;
          extra_written.push_back(idx);
        end
        write_texel(idx, $urandom);
      end else if (p < 95) begin
        if (area > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, area - 1);
        else idx = extra_written[$urandom_range(0, extra_written.size() - 1)];
        send_request(FUNC_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_request(FUNC_NONE, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
      end
    end
  endtask

  // stimulus
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_CANVAS_WIDTH;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_NONE;
    in_texel_index  <= '0;
    in_texel_value  <= '0;
    in_dab_u        <= '0;
    in_dab_v        <= '0;
    in_dab_radius   <= '0;
    in_dab_strength <= '0;
    calm = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // index extremes, reads before any dab, unused code
    write_texel(16'hFFFF, 32'hFFFF_FFFF);
    write_texel(16'h0000, 32'h0000_0000);
    extra_written.push_back(16'hFFFF);
    extra_written.push_back(16'h0000);
    send_request(FUNC_READ, 16'hFFFF, '0, '0, '0, '0, '0);
    send_request(FUNC_READ, 16'h0000, '1, '1, '1, '1, '1);
    send_request(FUNC_NONE, 16'hFFFF, '1, '1, '1, '1, '1);

    run_phase(8, 8, 0, 65536, 0, 0, 0, 0);
    // dab extremes: strength ends, UV ends, radius below one pixel, zero strength
    send_request(FUNC_DAB, '0, '0, 24'sd0, 24'sd0, 20'd0, 16'sh7FFF);
    send_request(FUNC_DAB, '0, '0, 24'sh7FFFFF, -24'sh800000, 20'h08000, -16'sh8000);
    send_request(FUNC_DAB, '0, '0, 24'sh008000, 24'sh00C000, 20'h04000, 16'sd0);
    send_request(FUNC_DAB, '0, '0, -24'sd1, 24'sd1, 20'h02000, 16'sd1);
    send_request(FUNC_DAB, '0, '0, 24'sh012345, 24'sh054321, 20'h06000, -16'sd1);
    for (int i = 0; i < 8; i++)
      send_request(FUNC_READ, i * 9, '0, '0, '0, '0, '0);

    run_phase(8, 8, 0, 65536, 0, 0, 100, 0);
    run_phase(1, 1, 3, -65536, 24'h7FFFFF, 24'h800000, 150, 1);
    run_phase(256, 1, 1, 131072, 24'h00ABCD, 24'hFF1234, 200, 0);
    run_phase(1, 256, 2, 24'h7FFFFF, 24'h812345, 24'h0F0F0F, 200, 0);
    run_phase(0, 5, 0, 65536, 0, 0, 100, 0);
    run_phase(511, 2, 3, 24'h800000, 24'h000001, 24'hFFFFFF, 150, 1);
    run_phase(16, 12, 1, 24'h00C000, $urandom, $urandom, 150, 0);
    run_phase(5, 3, 2, 0, $urandom, $urandom, 130, 0);
    run_phase(3, 7, 0, 24'hFE8000, $urandom, $urandom, 130, 0);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off
  initial begin
    int g;
    out_ready <= 1'b0;
    held = 0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      g = pick_gap();
      if (!held && sb.results >= 100) begin
        g = 800;
        held = 1;
      end
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // check each returned result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_read_value, out_canvas_dirty);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

// ===== radial_brush_dab_canvas_core.f =====
rtl/rbd_pkg.sv
rtl/rbd_ram.sv
rtl/rbd_queue.sv
rtl/rbd_front.sv
rtl/rbd_back.sv
rtl/radial_brush_dab_canvas_core.sv
test/tb_radial_brush_dab_canvas_core.sv
